/* rtl/aledspi_pkg.sv */
`timescale 1ns / 1ps

package aledspi_pkg;

   // request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_SEND  = 2'd1;
   localparam logic [1:0] REQ_PULL  = 2'd2;

   // register indexes on the csr port
   localparam int         CSR_INDEX_W   = 2;
   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_ONE_CODE  = 2'd1;
   localparam logic [1:0] CSR_ZERO_CODE = 2'd2;

   localparam logic [7:0] ONE_CODE_RST  = 8'hf8;
   localparam logic [7:0] ZERO_CODE_RST = 8'hc0;

   localparam int         COLOUR_W = 24;
   localparam logic [4:0] BIT_LAST = 5'd23;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEAD,
      PH_DATA,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] led_index;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] spi_byte;
      logic       frame_last;
   } rsp_payload_type;

endpackage

/* rtl/aledspi_ram.sv */
`timescale 1ns / 1ps

module aledspi_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/addressable_led_spi_frame_encoder.sv */
`timescale 1ns / 1ps

// Addressable LED SPI frame encoder. Colour writes fill a per-LED store of green, red
// and blue bytes; a send request (while enabled and idle) opens a frame, and each pull
// request then returns the next SPI byte: RESET_BYTES zero bytes, one code byte per
// colour bit for every LED (green, red, blue, MSB first), then RESET_BYTES zero bytes
// with the last one flagged. A request can be accepted every cycle unless stalled;
// a pull's byte passes through the pending register, alongside the registered read
// of the colour RAM, and then into the output register. Requests are stalled only
// while a byte waits behind a stalled output and, after reset, while the colour RAM
// is swept to zero (configuration writes are taken during the sweep).
module addressable_led_spi_frame_encoder #(
   parameter int LED_COUNT   = 16,
   parameter int RESET_BYTES = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  aledspi_pkg::req_payload_type          req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output aledspi_pkg::rsp_payload_type          rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [aledspi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                            csr_wdata
);

   import aledspi_pkg::*;

   localparam int            AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int            CW       = (RESET_BYTES > 1) ? $clog2(RESET_BYTES) : 1;
   localparam logic [AW-1:0] LED_LAST = AW'(LED_COUNT - 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(RESET_BYTES - 1);

   // configuration registers
   logic       enable_ff;
   logic [7:0] one_code_ff;
   logic [7:0] zero_code_ff;
   logic       csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         one_code_ff  <= ONE_CODE_RST;
         zero_code_ff <= ZERO_CODE_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_ONE_CODE:  one_code_ff  <= csr_wdata;
            CSR_ZERO_CODE: zero_code_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // request decode
   logic req_acc;
   logic is_write;
   logic is_send;
   logic is_pull;

   assign req_acc  = req_valid & ~req_stall;
   assign is_write = req_acc & (req_data.req_type == REQ_WRITE);
   assign is_send  = req_acc & (req_data.req_type == REQ_SEND);
   assign is_pull  = req_acc & (req_data.req_type == REQ_PULL);

   // clearing sweep after reset
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == LED_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // colour ram
   logic [AW+3:0]       idx_ext;
   logic [AW-1:0]       idx_addr;
   logic                led_ok;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [COLOUR_W-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [COLOUR_W-1:0] colour_q;
   logic [AW-1:0]       led_ff;
   logic [AW-1:0]       led_in;

   assign idx_ext     = {{AW{1'b0}}, req_data.led_index};
   assign idx_addr    = idx_ext[AW-1:0];
   assign led_ok      = 32'(req_data.led_index) < LED_COUNT;
   assign ram_wr_en   = clr_busy_ff | (is_write & led_ok);
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : idx_addr;
   assign ram_wr_data = clr_busy_ff ? '0 : {req_data.green, req_data.red, req_data.blue};

   aledspi_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (LED_COUNT)
   ) u_colour_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (led_ff),
      .rd_data (colour_q)
   );

   // frame sequencer
   phase_type     state_ff;
   phase_type     state_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [4:0]    bit_ff;
   logic [4:0]    bit_in;
   logic          pull_go;
   logic          pull_mem;
   logic          pull_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_IDLE;
         cnt_ff   <= '0;
         led_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         led_ff   <= led_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      led_in    = led_ff;
      bit_in    = bit_ff;
      pull_mem  = 1'b0;
      pull_last = 1'b0;
      unique case (state_ff)
         PH_IDLE: begin
            if (is_send && enable_ff) begin
               state_in = PH_LEAD;
               cnt_in   = '0;
               led_in   = '0;
               bit_in   = '0;
            end
         end
         PH_LEAD: begin
            if (is_pull) begin
               if (cnt_ff == CNT_LAST) begin
                  state_in = PH_DATA;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         PH_DATA: begin
            if (is_pull) begin
               pull_mem = 1'b1;
               if (bit_ff == BIT_LAST) begin
                  bit_in = '0;
                  if (led_ff == LED_LAST) begin
                     state_in = PH_TRAIL;
                     led_in   = '0;
                  end else begin
                     led_in = led_ff + 1'b1;
                  end
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         PH_TRAIL: begin
            if (is_pull) begin
               if (cnt_ff == CNT_LAST) begin
                  pull_last = 1'b1;
                  state_in  = PH_IDLE;
                  cnt_in    = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
      endcase
   end

   assign pull_go   = is_pull & (state_ff != PH_IDLE);
   assign ram_rd_en = pull_mem;

   // pending byte waits here for the ram read, then moves to the output register
   logic       pend_ff;
   logic       pend_mem_ff;
   logic       pend_last_ff;
   logic [4:0] pend_bit_ff;
   logic       slot_free;
   logic       pend_move;
   logic       colour_bit;
   logic [7:0] out_byte;

   assign slot_free  = ~rsp_valid | ~rsp_stall;
   assign pend_move  = pend_ff & slot_free;
   assign req_stall  = clr_busy_ff | (pend_ff & ~slot_free);
   assign colour_bit = colour_q[BIT_LAST - pend_bit_ff];
   assign out_byte   = pend_mem_ff ? (colour_bit ? one_code_ff : zero_code_ff) : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (pull_go) begin
         pend_ff <= 1'b1;
      end else if (pend_move) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pull_go) begin
         pend_mem_ff  <= pull_mem;
         pend_last_ff <= pull_last;
         pend_bit_ff  <= bit_ff;
      end
   end

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_data_ff.spi_byte   <= out_byte;
         rsp_data_ff.frame_last <= pend_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/aledspi_checker.sv */
`timescale 1ns / 1ps

module aledspi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input aledspi_pkg::req_payload_type        req_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input aledspi_pkg::rsp_payload_type        rsp_data,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   import aledspi_pkg::*;

   logic pull_acc;

   assign pull_acc = req_valid & ~req_stall & (req_data.req_type == REQ_PULL);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // the flagged byte is always a trailing reset byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last |-> rsp_data.spi_byte == 8'h00)
      else $error("frame_last on a nonzero byte");

   // a response only rises after a pull has passed through the pending register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pull_acc, 2))
      else $error("response without a pull");

   // the csr port never blocks a write
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind addressable_led_spi_frame_encoder aledspi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import aledspi_pkg::*;

   localparam int          LED_COUNT     = 16;
   localparam int          RESET_BYTES   = 256;
   localparam logic [1:0]  REQ_UNUSED    = 2'd3;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SEGMENT_ITEMS = 137;

   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_SILENT,
      ROW_BYTE,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type    kind;
      req_payload_type req;
      rsp_payload_type rsp;
      logic [1:0]      csr_idx;
      logic [7:0]      csr_val;
   } stim_row_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [7:0]      csr_wdata = '0;

   addressable_led_spi_frame_encoder #(
      .LED_COUNT   (LED_COUNT),
      .RESET_BYTES (RESET_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [COLOUR_W-1:0] led_colour [LED_COUNT];
   phase_type           frame_phase;
   int unsigned         phase_count;
   logic                reg_enable;
   logic [7:0]          reg_one_code;
   logic [7:0]          reg_zero_code;

   rsp_payload_type frame_bytes [$];
   int unsigned     errors      = 0;
   int unsigned     cycle_count = 0;
   int unsigned     send_gap_pct  = 6;
   int unsigned     rsp_stall_pct = 56;

   // typed expectation that overrides the predictor for one directed row
   bit              pin_active  = 1'b0;
   bit              pin_has_rsp = 1'b0;
   rsp_payload_type pin_rsp     = '0;

   stim_row_type directed_rows [$];

   function automatic void clear_predictor();
      foreach (led_colour[n]) led_colour[n] = '0;
      frame_phase   = PH_IDLE;
      phase_count   = 0;
      reg_enable    = 1'b0;
      reg_one_code  = ONE_CODE_RST;
      reg_zero_code = ZERO_CODE_RST;
   endfunction

   function automatic void apply_csr(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
         CSR_ENABLE:    reg_enable    = val[0];
         CSR_ONE_CODE:  reg_one_code  = val;
         CSR_ZERO_CODE: reg_zero_code = val;
         default: ;
      endcase
   endfunction

   function automatic void encode_request(input req_payload_type r, output bit has_rsp,
                                          output rsp_payload_type rsp);
      logic [COLOUR_W-1:0] word;
      int unsigned         led_pos;
      int unsigned         bit_pos;
      has_rsp = 1'b0;
      rsp     = '0;
      case (r.req_type)
         REQ_WRITE: begin
            if (r.led_index < LED_COUNT) led_colour[r.led_index] = {r.green, r.red, r.blue};
         end
         REQ_SEND: begin
            if (reg_enable && frame_phase == PH_IDLE) begin
               frame_phase = PH_LEAD;
               phase_count = 0;
            end
         end
         REQ_PULL: begin
            if (frame_phase != PH_IDLE) begin
               has_rsp = 1'b1;
               case (frame_phase)
                  PH_LEAD: begin
                     phase_count++;
                     if (phase_count >= RESET_BYTES) begin
                        frame_phase = PH_DATA;
                        phase_count = 0;
                     end
                  end
                  PH_DATA: begin
                     led_pos = phase_count / COLOUR_W;
                     bit_pos = phase_count % COLOUR_W;
                     word    = (led_pos < LED_COUNT) ? led_colour[led_pos] : '0;
                     rsp.spi_byte = word[COLOUR_W - 1 - bit_pos] ? reg_one_code
                                                                 : reg_zero_code;
                     phase_count++;
                     if (phase_count >= LED_COUNT * COLOUR_W) begin
                        frame_phase = PH_TRAIL;
                        phase_count = 0;
                     end
                  end
                  default: begin
                     if (phase_count + 1 >= RESET_BYTES) begin
                        rsp.frame_last = 1'b1;
                        frame_phase    = PH_IDLE;
                        phase_count    = 0;
                     end else begin
                        phase_count++;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] pick_colour();
      case ($urandom_range(3))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_code(input logic [7:0] rst_val);
      case ($urandom_range(4))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return rst_val;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly well-formed traffic: sends when idle, long runs of pulls during a frame
   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned     roll;
      roll        = $urandom_range(99);
      r.led_index = 4'($urandom_range(15));
      r.green     = pick_colour();
      r.red       = pick_colour();
      r.blue      = pick_colour();
      if (frame_phase == PH_IDLE) begin
         if (roll < 30)      r.req_type = REQ_WRITE;
         else if (roll < 70) r.req_type = REQ_SEND;
         else if (roll < 90) r.req_type = REQ_PULL;
         else                r.req_type = REQ_UNUSED;
      end else begin
         if (roll < 85)      r.req_type = REQ_PULL;
         else if (roll < 93) r.req_type = REQ_WRITE;
         else if (roll < 96) r.req_type = REQ_SEND;
         else                r.req_type = REQ_UNUSED;
      end
      return r;
   endfunction

   function automatic stim_row_type req_row(input row_kind_type kind, input logic [1:0] rtype,
                                            input logic [3:0] idx, input logic [7:0] g,
                                            input logic [7:0] r, input logic [7:0] b);
      stim_row_type row;
      row.kind    = kind;
      row.req     = '{req_type: rtype, led_index: idx, green: g, red: r, blue: b};
      row.rsp     = '0;
      row.csr_idx = '0;
      row.csr_val = '0;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx, input logic [7:0] val);
      stim_row_type row;
      row         = req_row(ROW_CSR, REQ_WRITE, 4'h0, 8'h00, 8'h00, 8'h00);
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   task automatic push_request(input req_payload_type r);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (frame_bytes.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_segment(input int unsigned item_target);
      req_payload_type r;
      int unsigned     counted;
      counted = 0;
      while (counted < item_target) begin
         r = random_request();
         counted++;
         if ($urandom_range(299) == 0) wait_drained();
         push_request(r);
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type made;
      rsp_payload_type want;
      bit              made_one;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            encode_request(req_data, made_one, made);
            if (pin_active) begin
               if (pin_has_rsp) frame_bytes.push_back(pin_rsp);
            end else if (made_one) begin
               frame_bytes.push_back(made);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes.size() == 0) begin
               $error("unexpected frame byte %0h last %0b", rsp_data.spi_byte,
                      rsp_data.frame_last);
               errors++;
            end else begin
               want = frame_bytes.pop_front();
               if (rsp_data.spi_byte !== want.spi_byte) begin
                  $error("spi_byte: expected %0h, got %0h", want.spi_byte, rsp_data.spi_byte);
                  errors++;
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0b, got %0b", want.frame_last,
                         rsp_data.frame_last);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      logic [7:0]   en_val;
      clear_predictor();

      directed_rows.push_back(req_row(ROW_SILENT, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_UNUSED, 4'hf, 8'hff, 8'hff, 8'hff));
      // send while disabled, then a pull to show no frame started
      directed_rows.push_back(req_row(ROW_SILENT, REQ_SEND, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_WRITE, 4'h0, 8'hff, 8'h00, 8'ha5));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_WRITE, 4'hf, 8'h00, 8'hff, 8'h5a));
      directed_rows.push_back(csr_row(CSR_ENABLE, 8'h01));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_SEND, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_BYTE, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_SEND, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_BYTE, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));
      // disable mid-frame with the upper data bits set
      directed_rows.push_back(csr_row(CSR_ENABLE, 8'hfe));
      directed_rows.push_back(req_row(ROW_BYTE, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_SEND, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(csr_row(CSR_ONE_CODE, 8'h00));
      directed_rows.push_back(csr_row(CSR_ZERO_CODE, 8'hff));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_WRITE, 4'hf, 8'hff, 8'hff, 8'hff));
      directed_rows.push_back(req_row(ROW_MODEL, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(req_row(ROW_SILENT, REQ_UNUSED, 4'h0, 8'h00, 8'h00, 8'h00));
      directed_rows.push_back(csr_row(CSR_ENABLE, 8'h01));
      directed_rows.push_back(req_row(ROW_MODEL, REQ_PULL, 4'h0, 8'h00, 8'h00, 8'h00));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.kind == ROW_CSR) begin
            write_register(row.csr_idx, row.csr_val);
         end else begin
            pin_active  = (row.kind != ROW_MODEL);
            pin_has_rsp = (row.kind == ROW_BYTE);
            pin_rsp     = row.rsp;
            push_request(row.req);
            pin_active  = 1'b0;
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_gap_pct  = 6;
               rsp_stall_pct = 56;
            end
            1: begin
               send_gap_pct  = 56;
               rsp_stall_pct = 6;
            end
            default: begin
               send_gap_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            en_val    = 8'($urandom_range(255));
            en_val[0] = (seg == 0) || ($urandom_range(3) != 0);
            write_register(CSR_ENABLE, en_val);
            write_register(CSR_ONE_CODE, pick_code(ONE_CODE_RST));
            write_register(CSR_ZERO_CODE, pick_code(ZERO_CODE_RST));
            run_segment(SEGMENT_ITEMS);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* addressable_led_spi_frame_encoder.f */
rtl/aledspi_pkg.sv
rtl/aledspi_ram.sv
rtl/addressable_led_spi_frame_encoder.sv
rtl/aledspi_checker.sv
dv/testbench.sv
